FILE: rtl/tftp_windowed_block_receiver_assert.svh
// Assertion macros used by the receiver back end
`ifndef TFTP_WINDOWED_BLOCK_RECEIVER_ASSERT_SVH
`define TFTP_WINDOWED_BLOCK_RECEIVER_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define TWBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWBR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/twbr_pkg.sv
// Types, codes and defaults for the TFTP windowed block receiver
`default_nettype none
package twbr_pkg;

    localparam int BLOCK_BYTES_DEFAULT = 512;
    localparam int MAX_WINDOW_DEFAULT  = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_PACKET = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    localparam logic [9:0] MIN_DGRAM_LEN = 10'd4;

    localparam logic [1:0] SK_NONE = 2'd0;
    localparam logic [1:0] SK_ACK  = 2'd1;
    localparam logic [1:0] SK_OACK = 2'd2;
    localparam logic [1:0] SK_TID  = 2'd3;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ACTIVE   = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_RETRIES  = 3'd3;
    localparam logic [2:0] ST_PEER_ERR = 3'd4;

    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_OPTIONS     = 2'd2;

    localparam logic [6:0] WINDOW_SIZE_RESET = 7'd1;
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        from_client;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [9:0]  datagram_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] ack_block;
        logic        store_payload;
        logic [2:0]  session_status;
    } out_item_t;

    typedef struct packed {
        logic [6:0] window_size;
        logic [7:0] max_retries;
        logic       options_negotiated;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_START,
        OP_PKT_SKIP,
        OP_TID,
        OP_PEER_ERR,
        OP_DATA,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        short_block;
        logic [15:0] block_number;
    } action_t;

endpackage
`default_nettype wire

FILE: rtl/twbr_front.sv
// Front end: accepts input transfers and classifies them into actions
`default_nettype none
module twbr_front
    import twbr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire logic     q_full,
    output logic          q_push,
    output action_t       q_data
);

    localparam logic [16:0] SHORT_LIMIT = 17'(BLOCK_BYTES + 4);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.block_number = in_data.block_number;
        q_data.short_block  = ({7'd0, in_data.datagram_length} < SHORT_LIMIT);
        q_data.op           = OP_NOP;
        unique case (in_data.cmd)
            CMD_START:
                q_data.op = OP_START;
            CMD_PACKET:
            begin
                if (in_data.datagram_length < MIN_DGRAM_LEN)
                    q_data.op = OP_PKT_SKIP;
                else if (!in_data.from_client)
                    q_data.op = OP_TID;
                else if (in_data.opcode == OPC_ERROR)
                    q_data.op = OP_PEER_ERR;
                else if (in_data.opcode == OPC_DATA)
                    q_data.op = OP_DATA;
                else
                    q_data.op = OP_PKT_SKIP;
            end
            CMD_TICK:
                q_data.op = OP_TICK;
            default:
                q_data.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/twbr_queue.sv
// Short action queue between front and back
`default_nettype none
module twbr_queue
    import twbr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire action_t push_data,
    output logic         full,
    input  wire logic    pop,
    output logic         head_valid,
    output action_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    action_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        if (push && !pop)
            count_next = count_reg + CNT_ONE;
        else if (pop && !push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: rtl/twbr_back.sv
// Back end: session state update and registered result
`default_nettype none
`include "tftp_windowed_block_receiver_assert.svh"
module twbr_back
    import twbr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    head_valid,
    input  wire action_t head,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output out_item_t    out_data
);

    localparam logic [15:0] WIN_MAX = 16'(MAX_WINDOW);

    logic [2:0]  status_reg, status_next;
    logic [15:0] expected_reg, expected_next;
    logic        hs_pending_reg, hs_pending_next;
    logic [6:0]  window_count_reg, window_count_next;
    logic [7:0]  retry_count_reg, retry_count_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, res;

    logic [15:0] win_eff;
    logic [15:0] prev_block;
    logic [6:0]  wc_inc;
    logic [7:0]  rc_inc;
    logic        active;

    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign active     = (status_reg == ST_ACTIVE);
    assign prev_block = expected_reg - 16'd1;
    assign wc_inc     = window_count_reg + 7'd1;
    assign rc_inc     = retry_count_reg + 8'd1;

    always_comb
    begin
        win_eff = (cfg.window_size == '0) ? 16'd1 : {9'd0, cfg.window_size};
        if (win_eff > WIN_MAX)
            win_eff = WIN_MAX;
    end

    always_comb
    begin
        status_next       = status_reg;
        expected_next     = expected_reg;
        hs_pending_next   = hs_pending_reg;
        window_count_next = window_count_reg;
        retry_count_next  = retry_count_reg;
        res.send_kind     = SK_NONE;
        res.ack_block     = '0;
        res.store_payload = 1'b0;
        if (pop)
        begin
            unique case (head.op)
                OP_START:
                begin
                    status_next       = ST_ACTIVE;
                    expected_next     = 16'd1;
                    hs_pending_next   = cfg.options_negotiated;
                    window_count_next = '0;
                    retry_count_next  = '0;
                    res.send_kind     = cfg.options_negotiated ? SK_OACK : SK_ACK;
                end
                OP_PKT_SKIP:
                begin
                    if (active)
                        retry_count_next = '0;
                end
                OP_TID:
                begin
                    if (active)
                    begin
                        retry_count_next = '0;
                        res.send_kind    = SK_TID;
                    end
                end
                OP_PEER_ERR:
                begin
                    if (active)
                    begin
                        retry_count_next = '0;
                        status_next      = ST_PEER_ERR;
                    end
                end
                OP_DATA:
                begin
                    if (active)
                    begin
                        retry_count_next = '0;
                        if (head.block_number == expected_reg)
                        begin
                            res.store_payload = 1'b1;
                            hs_pending_next   = 1'b0;
                            expected_next     = expected_reg + 16'd1;
                            window_count_next = wc_inc;
                            if (head.short_block)
                            begin
                                res.send_kind = SK_ACK;
                                res.ack_block = head.block_number;
                                status_next   = ST_COMPLETE;
                            end
                            else if ({9'd0, wc_inc} >= win_eff)
                            begin
                                res.send_kind     = SK_ACK;
                                res.ack_block     = head.block_number;
                                window_count_next = '0;
                            end
                        end
                        else if (head.block_number == prev_block)
                        begin
                            if (hs_pending_reg)
                                res.send_kind = SK_OACK;
                            else
                            begin
                                res.send_kind = SK_ACK;
                                res.ack_block = prev_block;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (active)
                    begin
                        retry_count_next = rc_inc;
                        if ((rc_inc >= cfg.max_retries) || (rc_inc == '0))
                            status_next = ST_RETRIES;
                        else if (hs_pending_reg)
                            res.send_kind = SK_OACK;
                        else
                        begin
                            res.send_kind = SK_ACK;
                            res.ack_block = prev_block;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.session_status = status_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg       <= ST_IDLE;
            expected_reg     <= 16'd1;
            hs_pending_reg   <= 1'b1;
            window_count_reg <= '0;
            retry_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            status_reg       <= status_next;
            expected_reg     <= expected_next;
            hs_pending_reg   <= hs_pending_next;
            window_count_reg <= window_count_next;
            retry_count_reg  <= retry_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // handshake still open means no block has been taken yet
    `TWBR_ASSERT_IMP(a_hs_expect_one, (status_reg == ST_ACTIVE) && hs_pending_reg,
        expected_reg == 16'd1, "handshake pending with expected block not one")
    `TWBR_ASSERT_IMP(a_store_kind, out_valid_reg && out_reg.store_payload,
        (out_reg.send_kind == SK_NONE) || (out_reg.send_kind == SK_ACK),
        "stored block answered with OACK or TID error")
    `TWBR_ASSERT_NXT(a_status_hold, !pop, $stable(status_reg),
        "session status changed without a dequeued action")

endmodule
`default_nettype wire

FILE: rtl/tftp_windowed_block_receiver.sv
// With the queue empty, an input transfer passes the action queue and then the output
// register before its result is valid. Throughput: 1 item per cycle while out_ready
// is high; the back-end session update, done as each action is dequeued, sets it.
// A 2-entry action queue and the output register let input and output stall apart.
// Reset (rst_n low, async): session idle, expected block 1, counters cleared,
// window 1, retries 5, options off.
`default_nettype none
module tftp_windowed_block_receiver
    import twbr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    q_full;
    logic    q_push;
    action_t q_in;
    logic    q_pop;
    logic    q_head_valid;
    action_t q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE: cfg_next.window_size        = cfg_data[6:0];
                CFG_MAX_RETRIES: cfg_next.max_retries        = cfg_data;
                CFG_OPTIONS:     cfg_next.options_negotiated = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size        <= WINDOW_SIZE_RESET;
            cfg_reg.max_retries        <= MAX_RETRIES_RESET;
            cfg_reg.options_negotiated <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    twbr_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    twbr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    twbr_back #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire
